[src/gtg_pkg.sv]
package gtg_pkg;

   localparam int CORDIC_ITERATIONS = 16;

   // fixed widths of the word fields
   localparam int POS_W   = 32;
   localparam int QUAT_W  = 16;
   localparam int SPEED_W = 16;
   localparam int DIFF_W  = POS_W + 1;
   localparam int QACC_W  = 35;
   localparam int ANG_W   = 32;
   localparam int CORDIC_W = 46;
   localparam int CORDIC_IN_W = 35;
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int PROD_W  = 48;
   localparam int CSR_W   = 31;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DIST_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE_SPEED   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_GAIN      = 2'd3;

   localparam logic signed [ANG_W-1:0] ANG_PI = 32'sd843314857;
   localparam logic signed [ANG_W:0] ANG_TWO_PI = 33'sd1686629714;
   localparam logic signed [CORDIC_W-1:0] NORM_LIMIT = 46'sd1 <<< 40;
   localparam logic signed [PROD_W-1:0] TURN_ROUND = 48'sd1 <<< 27;
   localparam logic signed [19:0] TURN_MIN = -20'sd2048;
   localparam logic signed [19:0] TURN_MAX = 20'sd4096;

   localparam logic signed [ANG_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
      32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
      32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
      32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32
   };

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DIFF, OP_SQ_X, OP_SQ_Y, OP_SQ_THR, OP_ARRIVE, OP_QUAT,
      OP_YAW_START, OP_THETA_ZERO, OP_SAVE_THETA, OP_BEAR_START, OP_SAVE_BEAR,
      OP_MUL, OP_UPDATE, OP_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_SQ_X, S_SQ_Y, S_SQ_THR, S_CMP, S_QUAT, S_GIMBAL,
      S_YAW_WAIT, S_BEAR_START, S_BEAR_WAIT, S_MUL, S_UPDATE, S_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_DONE} cordic_state_type;

   typedef struct packed {
      logic active;
      logic far;
      logic quat_last;
      logic gimbal;
      logic cordic_done;
      logic rsp_free;
   } dp_status_type;

endpackage

[src/gtg_req_if.sv]
interface gtg_req_if;
   logic               valid;
   logic               ready;
   logic               active;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [31:0] goal_x;
   logic signed [31:0] goal_y;

   modport source (output valid, active, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                   goal_x, goal_y, input ready);
   modport sink (input valid, active, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                 goal_x, goal_y, output ready);
endinterface

[src/gtg_rsp_if.sv]
interface gtg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] linear_speed;
   logic signed [15:0] turn_rate;
   logic               goal_reached;

   modport source (output valid, linear_speed, turn_rate, goal_reached, input ready);
   modport sink (input valid, linear_speed, turn_rate, goal_reached, output ready);
endinterface

[src/gtg_cordic.sv]
module gtg_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [gtg_pkg::CORDIC_IN_W-1:0] y_in,
   input  logic signed [gtg_pkg::CORDIC_IN_W-1:0] x_in,
   output logic                                  done,
   output logic signed [gtg_pkg::ANG_W-1:0]      angle
);
   import gtg_pkg::*;

   localparam logic [ATAN_IDX_W-1:0] LAST_ITER = ATAN_IDX_W'(CORDIC_ITERATIONS - 1);

   cordic_state_type state_ff, state_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in_r, y_ff, y_in_r;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic [ATAN_IDX_W-1:0] it_ff, it_in;
   logic signed [CORDIC_W-1:0] sx, sy;
   logic signed [ANG_W-1:0] z_step;
   logic small_xy;

   assign sx = x_ff >>> it_ff;
   assign sy = y_ff >>> it_ff;
   assign small_xy = (x_ff < NORM_LIMIT) && (x_ff > -NORM_LIMIT) &&
                     (y_ff < NORM_LIMIT) && (y_ff > -NORM_LIMIT);
   assign z_step = (y_ff >= 0) ? z_ff + ATAN_TABLE[it_ff] : z_ff - ATAN_TABLE[it_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff  <= x_in_r;
      y_ff  <= y_in_r;
      z_ff  <= z_in;
      it_ff <= it_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in_r   = x_ff;
      y_in_r   = y_ff;
      z_in     = z_ff;
      it_in    = it_ff;
      unique case (state_ff)
         C_IDLE, C_DONE: begin
            if (start) begin
               x_in_r   = CORDIC_W'(x_in);
               y_in_r   = CORDIC_W'(y_in);
               state_in = C_NORM;
            end
         end
         C_NORM: begin
            // double until one side reaches the normalizing limit
            if (x_ff == 0 && y_ff == 0) begin
               z_in     = '0;
               state_in = C_DONE;
            end else if (small_xy) begin
               x_in_r = x_ff <<< 1;
               y_in_r = y_ff <<< 1;
            end else begin
               it_in    = '0;
               state_in = C_ROT;
               if (x_ff < 0) begin
                  z_in   = (y_ff >= 0) ? ANG_PI : -ANG_PI;
                  x_in_r = -x_ff;
                  y_in_r = -y_ff;
               end else begin
                  z_in = '0;
               end
            end
         end
         C_ROT: begin
            if (y_ff >= 0) begin
               x_in_r = x_ff + sy;
               y_in_r = y_ff - sx;
            end else begin
               x_in_r = x_ff - sy;
               y_in_r = y_ff + sx;
            end
            z_in  = z_step;
            it_in = it_ff + 1'b1;
            if (it_ff == LAST_ITER) begin
               state_in = C_DONE;
               if (z_step > ANG_PI) begin
                  z_in = ANG_W'(33'(z_step) - ANG_TWO_PI);
               end else if (z_step <= -ANG_PI) begin
                  z_in = ANG_W'(33'(z_step) + ANG_TWO_PI);
               end
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   assign done  = (state_ff == C_DONE);
   assign angle = z_ff;
endmodule

[src/gtg_datapath.sv]
module gtg_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  gtg_pkg::dp_op_type             op,
   output gtg_pkg::dp_status_type         status,
   gtg_req_if.sink                        req_chan,
   gtg_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [gtg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gtg_pkg::CSR_W-1:0]      csr_wr_data
);
   import gtg_pkg::*;

   logic [30:0] dist_thr_ff;
   logic [14:0] yaw_thr_ff, cruise_ff, gain_ff;

   logic active_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, gx_ff, gy_ff;
   logic signed [QUAT_W-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic [DIFF_W-1:0] ax, ay;
   logic [61:0] sq_x, sq_y;
   logic big_ff;
   logic [62:0] sq_ff;
   logic [61:0] thr2_ff;
   logic [2:0] qk_ff;
   logic signed [QACC_W-1:0] norm_ff, m_ff, cy_ff, cx_ff, m2, abs_m2, qp_ext;
   logic signed [QUAT_W-1:0] qa, qb;
   logic signed [31:0] qp;
   logic signed [ANG_W-1:0] theta_ff, err_ff, abs_err;
   logic signed [ANG_W:0] diff;
   logic signed [PROD_W-1:0] prod_ff, mul_w;
   logic signed [19:0] wq;
   logic signed [SPEED_W-1:0] held_lin_ff, held_turn_ff, w_clamp;
   logic reached_ff;
   logic rsp_valid_ff;
   logic signed [SPEED_W-1:0] rsp_lin_ff, rsp_turn_ff;
   logic rsp_reached_ff;

   logic cordic_start, cordic_done;
   logic signed [CORDIC_IN_W-1:0] cordic_y, cordic_x;
   logic signed [ANG_W-1:0] cordic_angle;

   assign ax = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : dx_ff;
   assign ay = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : dy_ff;

   // full-width squares of the low 31 bits of the distance components
   assign sq_x = ax[30:0] * ax[30:0];
   assign sq_y = ay[30:0] * ay[30:0];

   // one quaternion product a step
   always_comb begin
      unique case (qk_ff)
         3'd0: begin qa = qw_ff; qb = qw_ff; end
         3'd1: begin qa = qx_ff; qb = qx_ff; end
         3'd2: begin qa = qy_ff; qb = qy_ff; end
         3'd3: begin qa = qz_ff; qb = qz_ff; end
         3'd4: begin qa = qx_ff; qb = qz_ff; end
         3'd5: begin qa = qw_ff; qb = qy_ff; end
         3'd6: begin qa = qx_ff; qb = qy_ff; end
         default: begin qa = qw_ff; qb = qz_ff; end
      endcase
   end
   assign qp     = qa * qb;
   assign qp_ext = QACC_W'(qp);
   assign m2     = m_ff <<< 1;
   assign abs_m2 = (m2 < 0) ? -m2 : m2;

   assign cordic_start = (op == OP_YAW_START) || (op == OP_BEAR_START);
   assign cordic_y = (op == OP_YAW_START) ? (cy_ff <<< 1) : CORDIC_IN_W'(dy_ff);
   assign cordic_x = (op == OP_YAW_START) ? cx_ff : CORDIC_IN_W'(dx_ff);

   gtg_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .y_in  (cordic_y),
      .x_in  (cordic_x),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   assign diff    = 33'(cordic_angle) - 33'(theta_ff);
   assign mul_w   = $signed({1'b0, gain_ff}) * err_ff;
   assign abs_err = (err_ff < 0) ? -err_ff : err_ff;
   assign wq      = prod_ff[PROD_W-1:28];
   always_comb begin
      if (wq < TURN_MIN) begin
         w_clamp = SPEED_W'(TURN_MIN);
      end else if (wq > TURN_MAX) begin
         w_clamp = SPEED_W'(TURN_MAX);
      end else begin
         w_clamp = wq[SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_thr_ff  <= 31'd16384;
         yaw_thr_ff   <= 15'd819;
         cruise_ff    <= 15'd512;
         gain_ff      <= 15'd4096;
         held_lin_ff  <= '0;
         held_turn_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_DIST_THRESHOLD: dist_thr_ff <= csr_wr_data;
               REG_YAW_THRESHOLD:  yaw_thr_ff  <= csr_wr_data[14:0];
               REG_CRUISE_SPEED:   cruise_ff   <= csr_wr_data[14:0];
               default:            gain_ff     <= csr_wr_data[14:0];
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end
         if (op == OP_ARRIVE) begin
            held_lin_ff  <= '0;
            held_turn_ff <= '0;
         end
         if (op == OP_UPDATE) begin
            if ({1'b0, abs_err} < {2'b00, yaw_thr_ff, 15'd0}) begin
               held_lin_ff <= SPEED_W'(cruise_ff);
            end else begin
               held_lin_ff  <= '0;
               held_turn_ff <= w_clamp;
            end
         end
      end

      unique case (op)
         OP_LOAD: begin
            active_ff  <= req_chan.active;
            px_ff      <= req_chan.pos_x;
            py_ff      <= req_chan.pos_y;
            gx_ff      <= req_chan.goal_x;
            gy_ff      <= req_chan.goal_y;
            qw_ff      <= req_chan.quat_w;
            qx_ff      <= req_chan.quat_x;
            qy_ff      <= req_chan.quat_y;
            qz_ff      <= req_chan.quat_z;
            reached_ff <= 1'b0;
            qk_ff      <= '0;
            norm_ff    <= '0;
            m_ff       <= '0;
            cy_ff      <= '0;
            cx_ff      <= '0;
         end
         OP_DIFF: begin
            dx_ff <= DIFF_W'(gx_ff) - DIFF_W'(px_ff);
            dy_ff <= DIFF_W'(gy_ff) - DIFF_W'(py_ff);
         end
         OP_SQ_X: begin
            big_ff <= (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
            sq_ff  <= {1'b0, sq_x};
         end
         OP_SQ_Y:   sq_ff   <= sq_ff + {1'b0, sq_y};
         OP_SQ_THR: thr2_ff <= dist_thr_ff * dist_thr_ff;
         OP_ARRIVE: reached_ff <= 1'b1;
         OP_QUAT: begin
            qk_ff <= qk_ff + 1'b1;
            unique case (qk_ff)
               3'd0, 3'd1: begin
                  norm_ff <= norm_ff + qp_ext;
                  cx_ff   <= cx_ff + qp_ext;
               end
               3'd2, 3'd3: begin
                  norm_ff <= norm_ff + qp_ext;
                  cx_ff   <= cx_ff - qp_ext;
               end
               3'd4:    m_ff  <= m_ff + qp_ext;
               3'd5:    m_ff  <= m_ff - qp_ext;
               default: cy_ff <= cy_ff + qp_ext;
            endcase
         end
         OP_THETA_ZERO: theta_ff <= '0;
         OP_SAVE_THETA: theta_ff <= cordic_angle;
         OP_SAVE_BEAR: begin
            // heading error wrapped to (-pi, pi]
            if (diff > 33'(ANG_PI)) begin
               err_ff <= ANG_W'(diff - ANG_TWO_PI);
            end else if (diff <= -33'(ANG_PI)) begin
               err_ff <= ANG_W'(diff + ANG_TWO_PI);
            end else begin
               err_ff <= diff[ANG_W-1:0];
            end
         end
         OP_MUL: prod_ff <= mul_w + TURN_ROUND;
         OP_OUT: begin
            rsp_lin_ff     <= held_lin_ff;
            rsp_turn_ff    <= held_turn_ff;
            rsp_reached_ff <= reached_ff;
         end
         default: ;
      endcase
   end

   assign status.active      = active_ff;
   assign status.far         = big_ff || (sq_ff > {1'b0, thr2_ff});
   assign status.quat_last   = (qk_ff == 3'd7);
   assign status.gimbal      = (abs_m2 >= norm_ff);
   assign status.cordic_done = cordic_done;
   assign status.rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.linear_speed = rsp_lin_ff;
   assign rsp_chan.turn_rate    = rsp_turn_ff;
   assign rsp_chan.goal_reached = rsp_reached_ff;
endmodule

[src/gtg_ctrl.sv]
module gtg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gtg_pkg::dp_status_type status,
   output gtg_pkg::dp_op_type     op
);
   import gtg_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // no word is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               op       = OP_LOAD;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            op       = OP_DIFF;
            state_in = status.active ? S_SQ_X : S_OUT;
         end
         S_SQ_X: begin
            op       = OP_SQ_X;
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            op       = OP_SQ_Y;
            state_in = S_SQ_THR;
         end
         S_SQ_THR: begin
            op       = OP_SQ_THR;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (status.far) begin
               state_in = S_QUAT;
            end else begin
               op       = OP_ARRIVE;
               state_in = S_OUT;
            end
         end
         S_QUAT: begin
            op = OP_QUAT;
            if (status.quat_last) begin
               state_in = S_GIMBAL;
            end
         end
         S_GIMBAL: begin
            if (status.gimbal) begin
               op       = OP_THETA_ZERO;
               state_in = S_BEAR_START;
            end else begin
               op       = OP_YAW_START;
               state_in = S_YAW_WAIT;
            end
         end
         S_YAW_WAIT: begin
            if (status.cordic_done) begin
               op       = OP_SAVE_THETA;
               state_in = S_BEAR_START;
            end
         end
         S_BEAR_START: begin
            op       = OP_BEAR_START;
            state_in = S_BEAR_WAIT;
         end
         S_BEAR_WAIT: begin
            if (status.cordic_done) begin
               op       = OP_SAVE_BEAR;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            op       = OP_MUL;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            op       = OP_UPDATE;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               op       = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[src/go_to_goal_heading_controller.sv]
// channel    dir  handshake           payload
// req_chan   in   valid/ready         active, pos_x/y, quat_w/x/y/z, goal_x/y
// rsp_chan   out  valid/ready         linear_speed, turn_rate, goal_reached
// csr_*      in   csr_wr_en, no wait  csr_index, csr_wr_data
// one word at a time: an inactive word skips to the output step, an arrival ends
// after the distance test, a far word adds the quaternion products and one atan2
// run of the shared cordic unit (two unless at gimbal lock), each run doing up to
// 40 normalizing doublings and then CORDIC_ITERATIONS rotation steps
// a stalled output register holds the sequencer in its output step until taken
// reset is synchronous: thresholds, gains and held speeds return to defaults
// a finished word waits in the output register while the next word is taken
module go_to_goal_heading_controller (
   input  logic                          clock,
   input  logic                          reset,
   gtg_req_if.sink                       req_chan,
   gtg_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [gtg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gtg_pkg::CSR_W-1:0]     csr_wr_data
);
   import gtg_pkg::*;

   dp_op_type     op;
   dp_status_type status;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   // sequencer: walks distance test, quaternion products, up to two atan2 runs, gain law
   gtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   // datapath: operand registers, shared multiplier paths, cordic, output register
   gtg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .status      (status),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );
endmodule

[dv/go_to_goal_heading_controller_tb.sv]
module go_to_goal_heading_controller_tb;
   import gtg_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [15:0] linear_speed;
      logic signed [15:0] turn_rate;
      logic               goal_reached;
   } cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_DIST_THRESHOLD;
   logic [CSR_W-1:0] csr_wr_data = '0;

   gtg_req_if req_chan ();
   gtg_rsp_if rsp_chan ();

   go_to_goal_heading_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // clock, 4 time units per cycle
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the registers and held speeds
   longint arrive_dist, straight_band, cruise, gain;
   longint held_lin, held_rate;
   cmd_type expected_cmds[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   longint cycle_count = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.active = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.quat_w = '0;
      req_chan.quat_x = '0;
      req_chan.quat_y = '0;
      req_chan.quat_z = '0;
      req_chan.goal_x = '0;
      req_chan.goal_y = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // fold an angle into (-pi, pi]
   function automatic longint fold_angle(longint a);
      if (a > ANG_PI) return a - 2 * longint'(ANG_PI);
      if (a <= -longint'(ANG_PI)) return a + 2 * longint'(ANG_PI);
      return a;
   endfunction

   // vectoring cordic, angle scaled by 2^28
   function automatic longint bearing_of(longint y, longint x);
      longint z, sx, sy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      while (abs64(x) < (64'sd1 <<< 40) && abs64(y) < (64'sd1 <<< 40)) begin
         x = x * 2;
         y = y * 2;
      end
      if (x < 0) begin
         z = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
         sx = floor_shift(x, i);
         sy = floor_shift(y, i);
         if (y >= 0) begin
            x = x + sy;
            y = y - sx;
            z = z + longint'(ATAN_TABLE[i]);
         end else begin
            x = x - sy;
            y = y + sx;
            z = z - longint'(ATAN_TABLE[i]);
         end
      end
      return fold_angle(z);
   endfunction

   // heading from the orientation quaternion, zero at gimbal lock
   function automatic longint heading_of(longint w, longint x, longint y, longint z);
      longint nrm, pitch_term;
      nrm = w * w + x * x + y * y + z * z;
      pitch_term = 2 * (x * z - w * y);
      if (abs64(pitch_term) >= nrm) return 0;
      return bearing_of(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
   endfunction

   function automatic cmd_type steer_command(logic act, logic signed [31:0] px,
                                             logic signed [31:0] py, logic signed [15:0] qw,
                                             logic signed [15:0] qx, logic signed [15:0] qy,
                                             logic signed [15:0] qz, logic signed [31:0] gx,
                                             logic signed [31:0] gy);
      cmd_type c;
      longint dx, dy, ax, ay, err, rate;
      logic far;
      c.goal_reached = 1'b0;
      if (act) begin
         dx = longint'(gx) - longint'(px);
         dy = longint'(gy) - longint'(py);
         ax = abs64(dx);
         ay = abs64(dy);
         if (ax >= (64'sd1 <<< 31) || ay >= (64'sd1 <<< 31))
            far = 1'b1;
         else
            far = (longint'(unsigned'(ax * ax + ay * ay)) < 0) ||
                  (64'(ax * ax + ay * ay) > 64'(arrive_dist * arrive_dist));
         if (far) begin
            err = fold_angle(bearing_of(dy, dx) - heading_of(qw, qx, qy, qz));
            if (abs64(err) < (straight_band <<< 15)) begin
               held_lin = cruise;
            end else begin
               rate = floor_shift(gain * err + (64'sd1 <<< 27), 28);
               if (rate < -2048) rate = -2048;
               if (rate > 4096) rate = 4096;
               held_lin = 0;
               held_rate = rate;
            end
         end else begin
            held_lin = 0;
            held_rate = 0;
            c.goal_reached = 1'b1;
         end
      end
      c.linear_speed = held_lin[15:0];
      c.turn_rate = held_rate[15:0];
      return c;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val[CSR_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_DIST_THRESHOLD: arrive_dist = val & 64'h7FFF_FFFF;
         REG_YAW_THRESHOLD:  straight_band = val & 64'h7FFF;
         REG_CRUISE_SPEED:   cruise = val & 64'h7FFF;
         default:            gain = val & 64'h7FFF;
      endcase
   endtask

   task automatic set_regs(longint d, longint y, longint c, longint g);
      write_reg(REG_DIST_THRESHOLD, d);
      write_reg(REG_YAW_THRESHOLD, y);
      write_reg(REG_CRUISE_SPEED, c);
      write_reg(REG_TURN_GAIN, g);
   endtask

   // send one word, predicting its command when it is accepted
   // valid stays up after acceptance so that words can follow back to back
   task automatic send_pose(logic act, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz,
                            logic signed [31:0] gx, logic signed [31:0] gy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.active <= act;
      req_chan.pos_x <= px;
      req_chan.pos_y <= py;
      req_chan.quat_w <= qw;
      req_chan.quat_x <= qx;
      req_chan.quat_y <= qy;
      req_chan.quat_z <= qz;
      req_chan.goal_x <= gx;
      req_chan.goal_y <= gy;
      do @(posedge clock); while (!req_chan.ready);
      expected_cmds.push_back(steer_command(act, px, py, qw, qx, qy, qz, gx, gy));
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // random heading from a unit-ish quaternion about z, sometimes tilted
   task automatic send_random_pose(logic act);
      logic signed [15:0] q[4];
      logic signed [31:0] px, py, gx, gy;
      int sel;
      for (int k = 0; k < 4; k++) q[k] = 16'($urandom_range(32768) - 16384);
      if ($urandom_range(3) != 0) begin
         q[1] = $signed(16'($urandom_range(600))) - 16'sd300;
         q[2] = $signed(16'($urandom_range(600))) - 16'sd300;
      end
      px = $urandom;
      py = $urandom;
      sel = $urandom_range(3);
      if (sel == 0) begin
         gx = $urandom;
         gy = $urandom;
      end else if (sel == 1) begin
         gx = px + ($signed($urandom_range(131072)) - 65536);
         gy = py + ($signed($urandom_range(131072)) - 65536);
      end else begin
         gx = px + ($signed($urandom_range(1 << 22)) - (1 << 21));
         gy = py + ($signed($urandom_range(1 << 22)) - (1 << 21));
      end
      send_pose(act, px, py, q[0], q[1], q[2], q[3], gx, gy);
   endtask

   task automatic test_directed();
      // identity pose, goal straight ahead, left, behind from both sides of the wrap, right
      send_pose(1, 0, 0, 16384, 0, 0, 0, 32'sd655360, 0);
      send_pose(1, 0, 0, 16384, 0, 0, 0, 0, 32'sd655360);
      send_pose(1, 0, 0, 16384, 0, 0, 0, -32'sd655360, 0);
      send_pose(1, 0, 0, 16384, 0, 0, 0, -32'sd655360, -32'sd1);
      send_pose(1, 0, 0, 16384, 0, 0, 0, 0, -32'sd655360);
      // inactive repeats held speeds
      send_pose(0, 0, 0, 16384, 0, 0, 0, 0, 0);
      // within arrival distance
      send_pose(1, 100, 100, 16384, 0, 0, 0, 200, 200);
      send_pose(0, 32'h7FFF_FFFF, 0, -16384, 16384, -16384, 16384, 0, 0);
      // extreme position differences
      send_pose(1, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 16384,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_pose(1, 32'sh7FFF_FFFF, 0, 16384, 0, 0, 0, 32'sh8000_0000, 0);
      // gimbal lock and the all-zero quaternion
      send_pose(1, 0, 0, 11585, 0, 11585, 0, 0, 32'sd655360);
      send_pose(1, 0, 0, 0, 0, 0, 0, 0, -32'sd655360);
      // all-ones quaternion bits and minimum values
      send_pose(1, 0, 0, -1, -1, -1, -1, 32'sd1000000, 32'sd5);
      send_pose(1, 0, 0, -16384, -16384, -16384, -16384, 32'sd3, -32'sd1000000);
      send_pose(1, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 5, 7);
      // goal on the robot
      send_pose(1, 12345, -999, 16384, 0, 0, 0, 12345, -999);
      drain();
      // zero threshold: goal on robot still arrives
      set_regs(0, 0, 32767, 32767);
      send_pose(1, 77, 77, 16384, 0, 0, 0, 77, 77);
      send_pose(1, 0, 0, 16384, 0, 0, 0, 1, 0);
      send_pose(1, 0, 0, 16384, 0, 0, 0, 0, 1);
      send_pose(1, 0, 0, 16384, 0, 0, 0, -1, 0);
      drain();
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int n = 0; n < count; n++) send_random_pose($urandom_range(7) != 0);
   endtask

   task automatic test_settings();
      // widest thresholds and gains, then a pause until all commands are back
      set_regs(32'h7FFF_FFFF, 25736, 32767, 32767);
      test_random(30, 0, 0);
      drain();
      set_regs($urandom_range(1 << 20), $urandom_range(25736), $urandom_range(32767),
               $urandom_range(32767));
      test_random(60, 0, 0);
      drain();
      set_regs(0, 0, 0, 0);
      test_random(30, 31, 31);
      drain();
      set_regs(16384, 819, 512, 4096);
   endtask

   // response side: random stalls and the comparison
   always @(posedge clock) begin
      cmd_type exp_cmd;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_cmds.size() == 0) begin
               $error("unexpected command word");
               error_count++;
            end else begin
               exp_cmd = expected_cmds.pop_front();
               if (rsp_chan.linear_speed !== exp_cmd.linear_speed) begin
                  $error("linear_speed expected %0d got %0d", exp_cmd.linear_speed,
                         rsp_chan.linear_speed);
                  error_count++;
               end
               if (rsp_chan.turn_rate !== exp_cmd.turn_rate) begin
                  $error("turn_rate expected %0d got %0d", exp_cmd.turn_rate,
                         rsp_chan.turn_rate);
                  error_count++;
               end
               if (rsp_chan.goal_reached !== exp_cmd.goal_reached) begin
                  $error("goal_reached expected %0d got %0d", exp_cmd.goal_reached,
                         rsp_chan.goal_reached);
                  error_count++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("go_to_goal_heading_controller_tb: done, errors");
         $finish;
      end
   end

   initial begin
      arrive_dist = 16384;
      straight_band = 819;
      cruise = 512;
      gain = 4096;
      held_lin = 0;
      held_rate = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      set_regs(16384, 819, 512, 4096);
      test_random(60, 0, 0);
      test_random(60, 64, 0);
      test_random(60, 0, 64);
      test_random(60, 31, 31);
      // sender holds off until every command is back
      drain();
      test_settings();
      test_random(20, 0, 0);
      drain();
      if (error_count == 0)
         $display("go_to_goal_heading_controller_tb: done, clean");
      else
         $display("go_to_goal_heading_controller_tb: done, errors");
      $finish;
   end
endmodule
